// ===== sv/kdd_pkg.sv =====
// shared types and constants of the keypoint detection decoder
// depends on nothing; every other file imports it
`timescale 1ns / 1ps

package kdd_pkg;

  localparam int POINT_COUNT = 5;
  localparam int OFFSET_COLS = 2 * POINT_COUNT;
  localparam int VALUE_W     = 16;
  localparam int COORD_W     = 24;
  localparam int ANCHOR_W    = 15;
  localparam int CONF_W      = 15;
  localparam int LABEL_W     = 4;
  localparam int KIND_W      = 3;
  localparam int LEVEL_W     = 2;
  localparam int GRID_W      = 7;
  localparam int SIZE_W      = 11;
  localparam int THRESH_W    = 9;
  localparam int SCALE_W     = 24;
  localparam int DIM_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int NUM_LEVELS  = 3;
  localparam int KEY_COUNT   = 6;

  localparam logic [KIND_W-1:0]  KIND_BOX   = 3'd0;
  localparam logic [KIND_W-1:0]  KIND_LAST  = 3'd6;
  localparam logic [LEVEL_W-1:0] LEVEL_DONE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONF_THRESHOLD = 3'd0,
    REG_INPUT_SIZE     = 3'd1,
    REG_INV_SCALE      = 3'd2,
    REG_OFFSET_X       = 3'd3,
    REG_OFFSET_Y       = 3'd4
  } cfg_reg_e;

  // one anchor that passed the threshold
  typedef struct packed {
    logic [OFFSET_COLS-1:0][VALUE_W-1:0] offsets;
    logic [GRID_W-1:0]                   grid_col;
    logic [GRID_W-1:0]                   grid_row;
    logic [LEVEL_W-1:0]                  level;
    logic [ANCHOR_W-1:0]                 anchor;
    logic [CONF_W-1:0]                   conf;
    logic [LABEL_W-1:0]                  class_idx;
    logic [LABEL_W-1:0]                  color_idx;
  } job_t;

endpackage

// ===== sv/kdd_if.sv =====
// valid/ready channel interfaces for input values and output records
// depends on kdd_pkg
`timescale 1ns / 1ps

interface kdd_in_if import kdd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] channel_value;
  logic                      frame_start;

  modport source (output valid, channel_value, frame_start, input ready);
  modport sink   (input valid, channel_value, frame_start, output ready);
endinterface

interface kdd_out_if import kdd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         record_kind;
  logic [ANCHOR_W-1:0]       anchor_number;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic [DIM_W-1:0]          box_width;
  logic [DIM_W-1:0]          box_height;
  logic [CONF_W-1:0]         confidence;
  logic [LABEL_W-1:0]        class_label;
  logic [LABEL_W-1:0]        color_label;
  logic                      last_record;

  modport source (output valid, record_kind, anchor_number, coord_x, coord_y, box_width,
                  box_height, confidence, class_label, color_label, last_record,
                  input ready);
  modport sink   (input valid, record_kind, anchor_number, coord_x, coord_y, box_width,
                  box_height, confidence, class_label, color_label, last_record,
                  output ready);
endinterface

// ===== sv/kdd_front.sv =====
// front end: walks rows and anchor grids, keeps best scores, queues passing anchors
// depends on kdd_pkg
`timescale 1ns / 1ps

module kdd_front import kdd_pkg::*; #(
  parameter int COLOR_COUNT    = 4,
  parameter int CLASS_COUNT    = 2,
  parameter int MAX_INPUT_SIZE = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic                       frame_start_i,
  input  logic [THRESH_W-1:0]        conf_threshold_i,
  input  logic [SIZE_W-1:0]          input_size_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output job_t                       push_job_o
);

  localparam int CONF_COL  = OFFSET_COLS;
  localparam int COLOR_COL = CONF_COL + 1;
  localparam int CLASS_COL = COLOR_COL + COLOR_COUNT;
  localparam int ROW_LEN   = CLASS_COL + CLASS_COUNT;
  localparam int COL_W     = $clog2(ROW_LEN);
  localparam int OFF_W     = $clog2(OFFSET_COLS);
  localparam int SIDE_W    = GRID_W + 1;

  logic [COL_W-1:0]          col_q, col_d, col;
  logic [ANCHOR_W-1:0]       anchor_q, anchor_d, cur_anchor;
  logic [GRID_W-1:0]         gcol_q, gcol_d, cur_gcol;
  logic [GRID_W-1:0]         grow_q, grow_d, cur_grow;
  logic [LEVEL_W-1:0]        lvl_q, lvl_d, cur_lvl;
  logic [OFFSET_COLS-1:0][VALUE_W-1:0] off_q;
  logic signed [VALUE_W-1:0] conf_q, conf_d;
  logic signed [VALUE_W-1:0] bcol_score_q, bcol_score_d, bcls_score_q, bcls_score_d;
  logic [LABEL_W-1:0]        bcol_idx_q, bcol_idx_d, bcls_idx_q, bcls_idx_d;
  logic [SIZE_W-1:0]         eff_size;
  logic [LABEL_W-1:0]        sub_idx_col, sub_idx_cls;
  logic                      accept, row_end, hit;
  logic [LEVEL_W-1:0]        lvl1, lvl2;
  logic [GRID_W-1:0]         gcol1, grow1;
  logic [SIDE_W-1:0]         side1, gcol_inc, grow_inc;

  function automatic logic [SIDE_W-1:0] side_of(logic [SIZE_W-1:0] sz,
                                                logic [LEVEL_W-1:0] l);
    logic [SIZE_W-1:0] s;
    s = sz >> (3 + int'(l));
    return SIDE_W'(s);
  endfunction

  // next level with a non-empty grid, or done
  function automatic logic [LEVEL_W-1:0] skip_of(logic [SIZE_W-1:0] sz,
                                                 logic [LEVEL_W-1:0] l);
    logic [LEVEL_W-1:0] r;
    r = l;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      if (r != LEVEL_DONE && side_of(sz, r) == '0) r = r + 1'b1;
    end
    return r;
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = push_ready_i;
  assign eff_size   = (input_size_i > SIZE_W'(MAX_INPUT_SIZE)) ? SIZE_W'(MAX_INPUT_SIZE)
                                                               : input_size_i;

  always_comb begin
    col        = frame_start_i ? '0 : col_q;
    cur_anchor = frame_start_i ? '0 : anchor_q;
    cur_gcol   = frame_start_i ? '0 : gcol_q;
    cur_grow   = frame_start_i ? '0 : grow_q;
    cur_lvl    = frame_start_i ? '0 : lvl_q;

    sub_idx_col = LABEL_W'(int'(col) - COLOR_COL);
    sub_idx_cls = LABEL_W'(int'(col) - CLASS_COL);

    conf_d       = conf_q;
    bcol_score_d = bcol_score_q;
    bcol_idx_d   = bcol_idx_q;
    bcls_score_d = bcls_score_q;
    bcls_idx_d   = bcls_idx_q;
    if (int'(col) == CONF_COL) begin
      conf_d = value_i;
    end else if (int'(col) >= COLOR_COL && int'(col) < CLASS_COL) begin
      if (sub_idx_col == '0 || value_i > bcol_score_q) begin
        bcol_score_d = value_i;
        bcol_idx_d   = sub_idx_col;
      end
    end else if (int'(col) >= CLASS_COL) begin
      if (sub_idx_cls == '0 || value_i > bcls_score_q) begin
        bcls_score_d = value_i;
        bcls_idx_d   = sub_idx_cls;
      end
    end

    row_end = (int'(col) + 1 >= ROW_LEN);

    // grid walk at the end of a row
    lvl1  = skip_of(eff_size, cur_lvl);
    gcol1 = (lvl1 != cur_lvl) ? '0 : cur_gcol;
    grow1 = (lvl1 != cur_lvl) ? '0 : cur_grow;
    side1 = side_of(eff_size, lvl1);
    hit   = (lvl1 != LEVEL_DONE) &&
            (conf_q >= $signed({{(VALUE_W-THRESH_W){1'b0}}, conf_threshold_i}));

    col_d    = row_end ? '0 : col + 1'b1;
    anchor_d = cur_anchor;
    gcol_d   = gcol1;
    grow_d   = grow1;
    lvl_d    = cur_lvl;
    gcol_inc = {1'b0, gcol1} + 1'b1;
    grow_inc = {1'b0, grow1} + 1'b1;
    lvl2     = lvl1;
    if (row_end) begin
      lvl_d = lvl1;
      if (lvl1 != LEVEL_DONE) begin
        anchor_d = cur_anchor + 1'b1;
        gcol_d   = GRID_W'(gcol_inc);
        if (gcol_inc >= side1) begin
          gcol_d = '0;
          grow_d = GRID_W'(grow_inc);
          if (grow_inc >= side1) begin
            grow_d = '0;
            lvl2   = lvl1 + 1'b1;
          end
        end
        lvl_d = skip_of(eff_size, lvl2);
        if (lvl_d != lvl2) begin
          gcol_d = '0;
          grow_d = '0;
        end
      end
    end

    push_valid_o         = accept && row_end && hit;
    push_job_o.offsets   = off_q;
    push_job_o.grid_col  = gcol1;
    push_job_o.grid_row  = grow1;
    push_job_o.level     = lvl1;
    push_job_o.anchor    = cur_anchor;
    push_job_o.conf      = CONF_W'(conf_q);
    push_job_o.class_idx = bcls_idx_d;
    push_job_o.color_idx = bcol_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      anchor_q     <= '0;
      gcol_q       <= '0;
      grow_q       <= '0;
      lvl_q        <= '0;
      conf_q       <= '0;
      bcol_score_q <= '0;
      bcol_idx_q   <= '0;
      bcls_score_q <= '0;
      bcls_idx_q   <= '0;
    end else if (accept) begin
      col_q        <= col_d;
      anchor_q     <= anchor_d;
      gcol_q       <= gcol_d;
      grow_q       <= grow_d;
      lvl_q        <= lvl_d;
      conf_q       <= conf_d;
      bcol_score_q <= bcol_score_d;
      bcol_idx_q   <= bcol_idx_d;
      bcls_score_q <= bcls_score_d;
      bcls_idx_q   <= bcls_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && int'(col) < CONF_COL) begin
      off_q[col[OFF_W-1:0]] <= value_i;
    end
  end

endmodule

// ===== sv/kdd_queue.sv =====
// two-entry queue of anchors between front and back end
// depends on kdd_pkg
`timescale 1ns / 1ps

module kdd_queue import kdd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule

// ===== sv/kdd_back.sv =====
// back end: maps anchor points to image space, forms keypoints and box, emits records
// depends on kdd_pkg
`timescale 1ns / 1ps

module kdd_back import kdd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  job_t                      job_i,
  input  logic [SCALE_W-1:0]        inv_scale_i,
  input  logic signed [COORD_W-1:0] offset_x_i,
  input  logic signed [COORD_W-1:0] offset_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [KIND_W-1:0]         kind_o,
  output logic [ANCHOR_W-1:0]       anchor_o,
  output logic signed [COORD_W-1:0] x_o,
  output logic signed [COORD_W-1:0] y_o,
  output logic [DIM_W-1:0]          w_o,
  output logic [DIM_W-1:0]          h_o,
  output logic [CONF_W-1:0]         conf_o,
  output logic [LABEL_W-1:0]        class_o,
  output logic [LABEL_W-1:0]        color_o,
  output logic                      last_o
);

  localparam int QW = 54;
  localparam int NW = 23;
  localparam int BW = COORD_W - 8;

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_SUM, ST_MID, ST_KEY, ST_BOX} state_e;

  state_e                    state_q;
  job_t                      job_q;
  logic [2:0]                pt_q;
  logic signed [QW-1:0]      px_q [POINT_COUNT];
  logic signed [QW-1:0]      py_q [POINT_COUNT];
  logic signed [QW-1:0]      s0x_q, s0y_q, s2x_q, s2y_q, mx_q, my_q, vx_q, vy_q;
  logic signed [COORD_W-1:0] kx_q [KEY_COUNT];
  logic signed [COORD_W-1:0] ky_q [KEY_COUNT];
  logic signed [COORD_W-1:0] hx_q [KEY_COUNT];
  logic signed [COORD_W-1:0] hy_q [KEY_COUNT];
  logic signed [BW-1:0]      left_q, top_q;
  logic [DIM_W-1:0]          bw_q, bh_q;
  logic [ANCHOR_W-1:0]       h_anchor_q;
  logic [CONF_W-1:0]         h_conf_q;
  logic [LABEL_W-1:0]        h_cls_q, h_col_q;
  logic                      hold_valid_q;
  logic [KIND_W-1:0]         rec_q;

  logic signed [NW-1:0]      nx, ny;
  logic signed [QW-1:0]      mul_x, mul_y;
  logic                      hold_free, load_hold;
  logic signed [COORD_W-1:0] minx, maxx, miny, maxy;
  logic signed [BW-1:0]      lft, rgt, tp, bot;
  logic [DIM_W-1:0]          box_w, box_h;
  logic [2:0]                key_idx;

  function automatic logic signed [COORD_W-1:0] to_q8(logic signed [QW-1:0] q);
    logic signed [QW-1:0] t;
    t = (q + (QW'(1) <<< 17)) >>> 18;
    if (t > QW'(signed'(24'sh7FFFFF)))       return 24'sh7FFFFF;
    else if (t < QW'(signed'(-24'sh800000))) return -24'sh800000;
    else                                     return COORD_W'(t);
  endfunction

  function automatic logic signed [NW-1:0] net_pt(logic [VALUE_W-1:0] off,
                                                  logic [GRID_W-1:0] g,
                                                  logic [LEVEL_W-1:0] l);
    logic signed [NW-1:0] s;
    s = NW'($signed(off)) + $signed({{(NW-GRID_W-8){1'b0}}, g, 8'b0});
    return s <<< (3 + int'(l));
  endfunction

  function automatic logic [DIM_W-1:0] span(logic signed [BW-1:0] lo,
                                            logic signed [BW-1:0] hi);
    logic signed [BW+1:0] d;
    d = (BW+2)'(hi) - (BW+2)'(lo) + (BW+2)'(1);
    if (d > (BW+2)'(65535)) return 16'hFFFF;
    else                    return DIM_W'(d);
  endfunction

  always_comb begin
    nx    = net_pt(job_q.offsets[{pt_q, 1'b0}], job_q.grid_col, job_q.level);
    ny    = net_pt(job_q.offsets[{pt_q, 1'b1}], job_q.grid_row, job_q.level);
    mul_x = QW'($signed({1'b0, inv_scale_i}) * nx) + (QW'(offset_x_i) <<< 16);
    mul_y = QW'($signed({1'b0, inv_scale_i}) * ny) + (QW'(offset_y_i) <<< 16);

    // box from keypoints one to four
    minx = kx_q[0]; maxx = kx_q[0]; miny = ky_q[0]; maxy = ky_q[0];
    for (int i = 1; i < 4; i++) begin
      if (kx_q[i] < minx) minx = kx_q[i];
      if (kx_q[i] > maxx) maxx = kx_q[i];
      if (ky_q[i] < miny) miny = ky_q[i];
      if (ky_q[i] > maxy) maxy = ky_q[i];
    end
    lft   = BW'(minx >>> 8);
    rgt   = BW'(maxx >>> 8);
    tp    = BW'(miny >>> 8);
    bot   = BW'(maxy >>> 8);
    box_w = span(lft, rgt);
    box_h = span(tp, bot);

    hold_free   = !hold_valid_q || (out_ready_i && rec_q == KIND_LAST);
    load_hold   = (state_q == ST_BOX) && hold_free;
    job_ready_o = (state_q == ST_IDLE);

    key_idx     = rec_q - 1'b1;
    out_valid_o = hold_valid_q;
    kind_o      = rec_q;
    anchor_o    = h_anchor_q;
    conf_o      = h_conf_q;
    class_o     = h_cls_q;
    color_o     = h_col_q;
    last_o      = (rec_q == KIND_LAST);
    if (rec_q == KIND_BOX) begin
      x_o = {left_q, 8'b0};
      y_o = {top_q, 8'b0};
      w_o = bw_q;
      h_o = bh_q;
    end else begin
      x_o = hx_q[key_idx];
      y_o = hy_q[key_idx];
      w_o = '0;
      h_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pt_q         <= '0;
      hold_valid_q <= 1'b0;
      rec_q        <= KIND_BOX;
    end else begin
      // a new anchor enters the holding register when it is empty or as the last record leaves
      if (load_hold) begin
        hold_valid_q <= 1'b1;
        rec_q        <= KIND_BOX;
      end else if (hold_valid_q && out_ready_i) begin
        if (rec_q == KIND_LAST) begin
          hold_valid_q <= 1'b0;
          rec_q        <= KIND_BOX;
        end else begin
          rec_q <= rec_q + 1'b1;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            pt_q    <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          px_q[pt_q] <= mul_x;
          py_q[pt_q] <= mul_y;
          if (int'(pt_q) == POINT_COUNT - 1) state_q <= ST_SUM;
          else pt_q <= pt_q + 1'b1;
        end
        ST_SUM: begin
          s0x_q   <= px_q[2] + px_q[3];
          s0y_q   <= py_q[2] + py_q[3];
          s2x_q   <= px_q[1] + px_q[4];
          s2y_q   <= py_q[1] + py_q[4];
          state_q <= ST_MID;
        end
        ST_MID: begin
          mx_q    <= s0x_q + s2x_q;
          my_q    <= s0y_q + s2y_q;
          vx_q    <= s0x_q - s2x_q;
          vy_q    <= s0y_q - s2y_q;
          state_q <= ST_KEY;
        end
        ST_KEY: begin
          kx_q[0] <= to_q8(s0x_q <<< 1);   ky_q[0] <= to_q8(s0y_q <<< 1);
          kx_q[1] <= to_q8(mx_q + vy_q);   ky_q[1] <= to_q8(my_q - vx_q);
          kx_q[2] <= to_q8(s2x_q <<< 1);   ky_q[2] <= to_q8(s2y_q <<< 1);
          kx_q[3] <= to_q8(mx_q - vy_q);   ky_q[3] <= to_q8(my_q + vx_q);
          kx_q[4] <= to_q8(mx_q);          ky_q[4] <= to_q8(my_q);
          kx_q[5] <= to_q8(px_q[0] <<< 2); ky_q[5] <= to_q8(py_q[0] <<< 2);
          state_q <= ST_BOX;
        end
        ST_BOX: begin
          if (hold_free) begin
            hx_q       <= kx_q;
            hy_q       <= ky_q;
            left_q     <= lft;
            top_q      <= tp;
            bw_q       <= box_w;
            bh_q       <= box_h;
            h_anchor_q <= job_q.anchor;
            h_conf_q   <= job_q.conf;
            h_cls_q    <= job_q.class_idx;
            h_col_q    <= job_q.color_idx;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/keypoint_detection_decoder.sv =====
// Anchor-free keypoint decoder. One signed Q8.8 channel value is taken per cycle
// whenever the two-entry anchor queue has room, so the input normally runs at one
// item per cycle with no gaps. Rows walk the stride 8, 16 and 32 grids; each row whose
// confidence reaches the threshold yields seven records (a box, then six keypoints),
// handed out one per cycle from a holding register while the output is ready. The
// back end works out one anchor in scale, sum, midpoint, rounding and box steps, the
// scale step on the shared pair of multipliers, overlapping with the output of the
// previous anchor; since a row is at least thirteen values long the back end keeps
// pace. Configuration may only be written while the block is idle.
// depends on kdd_pkg, kdd_if, kdd_front, kdd_queue, kdd_back
`timescale 1ns / 1ps

module keypoint_detection_decoder import kdd_pkg::*; #(
  parameter int COLOR_COUNT    = 4,
  parameter int CLASS_COUNT    = 2,
  parameter int MAX_INPUT_SIZE = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kdd_in_if.sink                in_ch,
  kdd_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [THRESH_W-1:0]        conf_threshold_q;
  logic [SIZE_W-1:0]          input_size_q;
  logic [SCALE_W-1:0]         inv_scale_q;
  logic signed [COORD_W-1:0]  offset_x_q, offset_y_q;

  // front to queue and queue to back
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_threshold_q <= THRESH_W'(179);
      input_size_q     <= SIZE_W'(640);
      inv_scale_q      <= SCALE_W'(65536);
      offset_x_q       <= '0;
      offset_y_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CONF_THRESHOLD: conf_threshold_q <= cfg_data_i[THRESH_W-1:0];
        REG_INPUT_SIZE:     input_size_q     <= cfg_data_i[SIZE_W-1:0];
        REG_INV_SCALE:      inv_scale_q      <= cfg_data_i[SCALE_W-1:0];
        REG_OFFSET_X:       offset_x_q       <= cfg_data_i[COORD_W-1:0];
        REG_OFFSET_Y:       offset_y_q       <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // row walker and score tracking
  kdd_front #(
    .COLOR_COUNT   (COLOR_COUNT),
    .CLASS_COUNT   (CLASS_COUNT),
    .MAX_INPUT_SIZE(MAX_INPUT_SIZE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_ready_o      (in_ch.ready),
    .value_i         (in_ch.channel_value),
    .frame_start_i   (in_ch.frame_start),
    .conf_threshold_i(conf_threshold_q),
    .input_size_i    (input_size_q),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_job_o      (push_job)
  );

  // decouples row intake from record output
  kdd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_job_o   (pop_job)
  );

  // coordinate maths and record output
  kdd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .job_i      (pop_job),
    .inv_scale_i(inv_scale_q),
    .offset_x_i (offset_x_q),
    .offset_y_i (offset_y_q),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .kind_o     (out_ch.record_kind),
    .anchor_o   (out_ch.anchor_number),
    .x_o        (out_ch.coord_x),
    .y_o        (out_ch.coord_y),
    .w_o        (out_ch.box_width),
    .h_o        (out_ch.box_height),
    .conf_o     (out_ch.confidence),
    .class_o    (out_ch.class_label),
    .color_o    (out_ch.color_label),
    .last_o     (out_ch.last_record)
  );

endmodule
